### hdl/abs_pkg.sv
// Alternating-bit sender: shared types, codes, defaults and the checksum step.
// No dependencies; used by every module of the block.
package abs_pkg;

  localparam int MESSAGE_BYTES_DEFAULT = 20;
  localparam int QUEUE_DEPTH_DEFAULT   = 16;
  localparam logic [15:0] TIMEOUT_RESET = 16'd20;

  typedef enum logic [1:0] {
    CMD_MESSAGE = 2'd0,
    CMD_PACKET  = 2'd1,
    CMD_EXPIRY  = 2'd2,
    CMD_SPARE   = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    KIND_BYTE   = 2'd0,
    KIND_TSTART = 2'd1,
    KIND_TSTOP  = 2'd2,
    KIND_DROP   = 2'd3
  } kind_t;

  typedef struct packed {
    logic [1:0]         command;
    logic [7:0]         data_byte;
    logic               last_byte;
    logic signed [31:0] pkt_seqnum;
    logic signed [31:0] pkt_acknum;
    logic signed [31:0] pkt_checksum;
  } item_t;

  typedef struct packed {
    kind_t              kind;
    logic               out_seqnum;
    logic signed [31:0] out_checksum;
    logic [7:0]         out_byte;
    logic               out_last;
    logic [15:0]        out_timeout;
  } result_t;

  typedef struct packed {
    logic wr_en;
    logic rd_en;
  } mem_ctl_t;

  // One shift-add step with the byte sign-extended.
  function automatic logic [31:0] sum_step(input logic [31:0] acc, input logic [7:0] b);
    return {acc[30:0], 1'b0} + {{24{b[7]}}, b};
  endfunction

endpackage

### hdl/abs_queue_mem.sv
// Message queue store: one byte row per message slot, synchronous read.
// Depends on abs_pkg.
module abs_queue_mem import abs_pkg::*; #(
  parameter int MESSAGE_BYTES = MESSAGE_BYTES_DEFAULT,
  parameter int QUEUE_DEPTH   = QUEUE_DEPTH_DEFAULT,
  localparam int IDX_W  = (MESSAGE_BYTES > 1) ? $clog2(MESSAGE_BYTES) : 1,
  localparam int SLOT_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1
) (
  input  logic              clk,
  input  mem_ctl_t          ctl,
  input  logic [SLOT_W-1:0] wr_slot,
  input  logic [IDX_W-1:0]  wr_idx,
  input  logic [7:0]        wr_data,
  input  logic [SLOT_W-1:0] rd_slot,
  input  logic [IDX_W-1:0]  rd_idx,
  output logic [7:0]        rd_data
);

  localparam int DEPTH  = QUEUE_DEPTH * MESSAGE_BYTES;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [7:0]        mem [DEPTH];
  logic [ADDR_W-1:0] wr_addr;
  logic [ADDR_W-1:0] rd_addr;

  assign wr_addr = ADDR_W'(wr_slot) * ADDR_W'(MESSAGE_BYTES) + ADDR_W'(wr_idx);
  assign rd_addr = ADDR_W'(rd_slot) * ADDR_W'(MESSAGE_BYTES) + ADDR_W'(rd_idx);

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (ctl.rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

### hdl/abs_resend_mem.sv
// Resend buffer: the kept packet payload, synchronous read.
// Depends on abs_pkg.
module abs_resend_mem import abs_pkg::*; #(
  parameter int MESSAGE_BYTES = MESSAGE_BYTES_DEFAULT,
  localparam int IDX_W = (MESSAGE_BYTES > 1) ? $clog2(MESSAGE_BYTES) : 1
) (
  input  logic             clk,
  input  mem_ctl_t         ctl,
  input  logic [IDX_W-1:0] wr_idx,
  input  logic [7:0]       wr_data,
  input  logic [IDX_W-1:0] rd_idx,
  output logic [7:0]       rd_data
);

  logic [7:0] mem [MESSAGE_BYTES];

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[wr_idx] <= wr_data;
    end
    if (ctl.rd_en) begin
      rd_data <= mem[rd_idx];
    end
  end

endmodule

### hdl/abs_ctrl.sv
// Sender control: protocol state, queue pointers, checksums, output register.
// Depends on abs_pkg; drives abs_queue_mem and abs_resend_mem.
module abs_ctrl import abs_pkg::*; #(
  parameter int MESSAGE_BYTES = MESSAGE_BYTES_DEFAULT,
  parameter int QUEUE_DEPTH   = QUEUE_DEPTH_DEFAULT,
  localparam int IDX_W  = (MESSAGE_BYTES > 1) ? $clog2(MESSAGE_BYTES) : 1,
  localparam int SLOT_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              timeout_wr_en,
  input  logic [15:0]       timeout_wr_data,
  input  logic              in_valid,
  output logic              in_ready,
  input  item_t             item,
  output logic              out_valid,
  input  logic              out_ready,
  output result_t           result,
  output mem_ctl_t          q_ctl,
  output logic [SLOT_W-1:0] q_wslot,
  output logic [IDX_W-1:0]  q_widx,
  output logic [7:0]        q_wdata,
  output logic [SLOT_W-1:0] q_rslot,
  output logic [IDX_W-1:0]  q_ridx,
  input  logic [7:0]        q_rdata,
  output mem_ctl_t          r_ctl,
  output logic [IDX_W-1:0]  r_widx,
  output logic [7:0]        r_wdata,
  output logic [IDX_W-1:0]  r_ridx,
  input  logic [7:0]        r_rdata
);

  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int SUM_W = CNT_W + 1;
  localparam int SH_W  = $clog2(MESSAGE_BYTES + 1);
  localparam logic [IDX_W-1:0]  IDX_LAST  = IDX_W'(MESSAGE_BYTES - 1);
  localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0]  CNT_FULL  = CNT_W'(QUEUE_DEPTH);

  typedef enum logic [9:0] {
    S_IDLE   = 10'b0000000001,
    S_PAD    = 10'b0000000010,
    S_FILL   = 10'b0000000100,
    S_TSTART = 10'b0000001000,
    S_KPRIME = 10'b0000010000,
    S_KSEND  = 10'b0000100000,
    S_QPRIME = 10'b0001000000,
    S_QSEND  = 10'b0010000000,
    S_RXCHK  = 10'b0100000000,
    S_TSTOP  = 10'b1000000000
  } state_t;

  state_t            state, state_next;
  logic [15:0]       timeout;
  logic              seq_bit, seq_bit_next;
  logic              awaiting, awaiting_next;
  logic [SLOT_W-1:0] head, head_next;
  logic [CNT_W-1:0]  count, count_next;
  logic [IDX_W-1:0]  tx_idx, tx_idx_next;
  logic              tx_zs, tx_zs_next;
  logic              tx_qmode, tx_qmode_next;
  logic [31:0]       tx_acc, tx_acc_next;
  logic [IDX_W-1:0]  rx_idx, rx_idx_next;
  logic [31:0]       rx_acc, rx_acc_next;
  logic [IDX_W-1:0]  snd_idx, snd_idx_next;
  logic [31:0]       snd_acc, snd_acc_next;
  logic              snd_zero, snd_zero_next;
  logic [31:0]       resend_chk, resend_chk_next;
  logic [31:0]       rx_sum, rx_sum_next;
  logic [IDX_W-1:0]  rx_cnt, rx_cnt_next;
  logic [31:0]       rx_hdr, rx_hdr_next;
  logic [31:0]       rx_chk, rx_chk_next;
  logic [31:0]       rx_ack, rx_ack_next;
  logic              out_valid_next;
  logic              emit;
  result_t           res;

  logic              out_free;
  logic              accept;
  logic [SUM_W-1:0]  tail_sum;
  logic [SLOT_W-1:0] tail;
  logic              tx_first, tx_last_idx, msg_end, qmode, drop, zs_cur;
  logic [7:0]        tx_b;
  logic [31:0]       tx_step, pad_acc;
  logic [7:0]        q_b;
  logic [31:0]       snd_step;
  logic [31:0]       rx_step;
  logic              rx_end;
  logic [SH_W-1:0]   rx_shamt;
  logic [31:0]       rx_calc;
  logic              rx_ok;

  assign out_free = !out_valid || out_ready;
  assign in_ready = (state == S_IDLE) && out_free;
  assign accept   = in_valid && in_ready;

  assign tail_sum = {{(SUM_W - SLOT_W){1'b0}}, head} + {1'b0, count};
  assign tail = (tail_sum >= SUM_W'(QUEUE_DEPTH)) ? SLOT_W'(tail_sum - SUM_W'(QUEUE_DEPTH))
                                                  : SLOT_W'(tail_sum);

  assign tx_first    = (tx_idx == '0);
  assign tx_last_idx = (tx_idx == IDX_LAST);
  assign msg_end     = item.last_byte || tx_last_idx;
  assign qmode       = tx_first ? awaiting : tx_qmode;
  assign drop        = tx_first ? (awaiting && (count == CNT_FULL)) : tx_zs;
  assign zs_cur      = tx_first ? 1'b0 : tx_zs;
  assign tx_b        = zs_cur ? 8'd0 : item.data_byte;
  assign tx_step     = sum_step(tx_first ? {31'd0, seq_bit} : tx_acc, tx_b);
  assign pad_acc     = {tx_acc[30:0], 1'b0};

  assign q_b      = snd_zero ? 8'd0 : q_rdata;
  assign snd_step = sum_step(snd_acc, q_b);

  assign rx_step = sum_step(rx_acc, item.data_byte);
  assign rx_end  = item.last_byte || (rx_idx == IDX_LAST);

  // header weight and missing trailing bytes folded in as shifts
  assign rx_shamt = SH_W'(MESSAGE_BYTES - 1) - SH_W'(rx_cnt);
  assign rx_calc  = ~((rx_hdr << MESSAGE_BYTES) + (rx_sum << rx_shamt));
  assign rx_ok    = awaiting && (rx_calc == rx_chk) && (rx_ack == {31'd0, seq_bit});

  always_comb begin
    state_next      = state;
    seq_bit_next    = seq_bit;
    awaiting_next   = awaiting;
    head_next       = head;
    count_next      = count;
    tx_idx_next     = tx_idx;
    tx_zs_next      = tx_zs;
    tx_qmode_next   = tx_qmode;
    tx_acc_next     = tx_acc;
    rx_idx_next     = rx_idx;
    rx_acc_next     = rx_acc;
    snd_idx_next    = snd_idx;
    snd_acc_next    = snd_acc;
    snd_zero_next   = snd_zero;
    resend_chk_next = resend_chk;
    rx_sum_next     = rx_sum;
    rx_cnt_next     = rx_cnt;
    rx_hdr_next     = rx_hdr;
    rx_chk_next     = rx_chk;
    rx_ack_next     = rx_ack;
    emit            = 1'b0;
    res             = '0;
    q_ctl           = '0;
    q_wslot         = tail;
    q_widx          = tx_idx;
    q_wdata         = item.data_byte;
    q_rslot         = head;
    q_ridx          = snd_idx;
    r_ctl           = '0;
    r_widx          = tx_idx;
    r_wdata         = tx_b;
    r_ridx          = snd_idx;

    case (state)
      S_IDLE: begin
        if (accept) begin
          case (item.command)
            CMD_MESSAGE: begin
              if (qmode) begin
                q_ctl.wr_en = !drop;
                if (!msg_end) begin
                  tx_idx_next   = tx_idx + IDX_W'(1);
                  tx_qmode_next = 1'b1;
                  tx_zs_next    = drop;
                end else if (drop) begin
                  emit          = 1'b1;
                  res.kind      = KIND_DROP;
                  tx_idx_next   = '0;
                  tx_zs_next    = 1'b0;
                  tx_qmode_next = 1'b0;
                end else if (tx_last_idx) begin
                  count_next    = count + CNT_W'(1);
                  tx_idx_next   = '0;
                  tx_zs_next    = 1'b0;
                  tx_qmode_next = 1'b0;
                  state_next    = awaiting ? S_IDLE : S_QPRIME;
                end else begin
                  tx_idx_next   = tx_idx + IDX_W'(1);
                  tx_qmode_next = 1'b1;
                  tx_zs_next    = 1'b0;
                  state_next    = S_FILL;
                end
              end else begin
                r_ctl.wr_en    = 1'b1;
                emit           = 1'b1;
                res.kind       = KIND_BYTE;
                res.out_seqnum = seq_bit;
                res.out_byte   = tx_b;
                tx_acc_next    = tx_step;
                tx_zs_next     = zs_cur || (tx_b == 8'd0);
                tx_qmode_next  = 1'b0;
                if (!msg_end) begin
                  tx_idx_next = tx_idx + IDX_W'(1);
                end else if (tx_last_idx) begin
                  res.out_checksum = ~tx_step;
                  res.out_last     = 1'b1;
                  resend_chk_next  = ~tx_step;
                  tx_idx_next      = '0;
                  tx_zs_next       = 1'b0;
                  tx_acc_next      = '0;
                  state_next       = S_TSTART;
                end else begin
                  tx_idx_next = tx_idx + IDX_W'(1);
                  state_next  = S_PAD;
                end
              end
            end
            CMD_PACKET: begin
              if (!rx_end) begin
                rx_acc_next = rx_step;
                rx_idx_next = rx_idx + IDX_W'(1);
              end else begin
                rx_sum_next = rx_step;
                rx_cnt_next = rx_idx;
                rx_hdr_next = item.pkt_seqnum + item.pkt_acknum;
                rx_chk_next = item.pkt_checksum;
                rx_ack_next = item.pkt_acknum;
                rx_acc_next = '0;
                rx_idx_next = '0;
                state_next  = S_RXCHK;
              end
            end
            CMD_EXPIRY: begin
              if (awaiting) begin
                state_next = S_KPRIME;
              end
            end
            default: begin
            end
          endcase
        end
      end

      S_PAD: begin
        if (out_free) begin
          emit           = 1'b1;
          res.kind       = KIND_BYTE;
          res.out_seqnum = seq_bit;
          r_ctl.wr_en    = 1'b1;
          r_wdata        = 8'd0;
          tx_acc_next    = pad_acc;
          if (tx_last_idx) begin
            res.out_checksum = ~pad_acc;
            res.out_last     = 1'b1;
            resend_chk_next  = ~pad_acc;
            tx_idx_next      = '0;
            tx_zs_next       = 1'b0;
            tx_acc_next      = '0;
            state_next       = S_TSTART;
          end else begin
            tx_idx_next = tx_idx + IDX_W'(1);
          end
        end
      end

      S_FILL: begin
        q_ctl.wr_en = 1'b1;
        q_wdata     = 8'd0;
        if (tx_last_idx) begin
          count_next    = count + CNT_W'(1);
          tx_idx_next   = '0;
          tx_zs_next    = 1'b0;
          tx_qmode_next = 1'b0;
          state_next    = awaiting ? S_IDLE : S_QPRIME;
        end else begin
          tx_idx_next = tx_idx + IDX_W'(1);
        end
      end

      S_TSTART: begin
        if (out_free) begin
          emit            = 1'b1;
          res.kind        = KIND_TSTART;
          res.out_timeout = timeout;
          awaiting_next   = 1'b1;
          state_next      = S_IDLE;
        end
      end

      S_KPRIME: begin
        r_ctl.rd_en  = 1'b1;
        r_ridx       = '0;
        snd_idx_next = '0;
        state_next   = S_KSEND;
      end

      S_KSEND: begin
        if (out_free) begin
          emit           = 1'b1;
          res.kind       = KIND_BYTE;
          res.out_seqnum = seq_bit;
          res.out_byte   = r_rdata;
          if (snd_idx == IDX_LAST) begin
            res.out_checksum = resend_chk;
            res.out_last     = 1'b1;
            state_next       = S_TSTART;
          end else begin
            r_ctl.rd_en  = 1'b1;
            r_ridx       = snd_idx + IDX_W'(1);
            snd_idx_next = snd_idx + IDX_W'(1);
          end
        end
      end

      S_QPRIME: begin
        q_ctl.rd_en   = 1'b1;
        q_ridx        = '0;
        snd_idx_next  = '0;
        snd_acc_next  = {31'd0, seq_bit};
        snd_zero_next = 1'b0;
        state_next    = S_QSEND;
      end

      S_QSEND: begin
        if (out_free) begin
          emit           = 1'b1;
          res.kind       = KIND_BYTE;
          res.out_seqnum = seq_bit;
          res.out_byte   = q_b;
          r_ctl.wr_en    = 1'b1;
          r_widx         = snd_idx;
          r_wdata        = q_b;
          if (snd_idx == IDX_LAST) begin
            res.out_checksum = ~snd_step;
            res.out_last     = 1'b1;
            resend_chk_next  = ~snd_step;
            head_next        = (head == SLOT_LAST) ? '0 : head + SLOT_W'(1);
            count_next       = count - CNT_W'(1);
            state_next       = S_TSTART;
          end else begin
            q_ctl.rd_en   = 1'b1;
            q_ridx        = snd_idx + IDX_W'(1);
            snd_idx_next  = snd_idx + IDX_W'(1);
            snd_acc_next  = snd_step;
            snd_zero_next = snd_zero || (q_b == 8'd0);
          end
        end
      end

      S_RXCHK: begin
        state_next = rx_ok ? S_TSTOP : S_IDLE;
      end

      S_TSTOP: begin
        if (out_free) begin
          emit          = 1'b1;
          res.kind      = KIND_TSTOP;
          seq_bit_next  = !seq_bit;
          awaiting_next = 1'b0;
          state_next    = (count != '0) ? S_QPRIME : S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign out_valid_next = emit || (out_valid && !out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      timeout   <= TIMEOUT_RESET;
      seq_bit   <= 1'b0;
      awaiting  <= 1'b0;
      head      <= '0;
      count     <= '0;
      tx_idx    <= '0;
      tx_zs     <= 1'b0;
      tx_qmode  <= 1'b0;
      tx_acc    <= '0;
      rx_idx    <= '0;
      rx_acc    <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      seq_bit   <= seq_bit_next;
      awaiting  <= awaiting_next;
      head      <= head_next;
      count     <= count_next;
      tx_idx    <= tx_idx_next;
      tx_zs     <= tx_zs_next;
      tx_qmode  <= tx_qmode_next;
      tx_acc    <= tx_acc_next;
      rx_idx    <= rx_idx_next;
      rx_acc    <= rx_acc_next;
      out_valid <= out_valid_next;
      if (timeout_wr_en) begin
        timeout <= timeout_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    snd_idx    <= snd_idx_next;
    snd_acc    <= snd_acc_next;
    snd_zero   <= snd_zero_next;
    resend_chk <= resend_chk_next;
    rx_sum     <= rx_sum_next;
    rx_cnt     <= rx_cnt_next;
    rx_hdr     <= rx_hdr_next;
    rx_chk     <= rx_chk_next;
    rx_ack     <= rx_ack_next;
    if (emit) begin
      result <= res;
    end
  end

endmodule

### hdl/alternating_bit_sender_unit.sv
// Alternating-bit protocol sender, top level.
// Input beats carry a command in tuser: message byte, network packet byte or
// timer expiry. Message bytes sent while idle go out at one beat per cycle
// while the output is free, with the sequence bit; bytes after the first zero
// go out as zero, short messages are padded, the last beat carries the
// checksum, then a timer-start beat with the retransmit timeout follows.
// Messages that arrive while an ACK is pending go to a queue of QUEUE_DEPTH
// slots; a full queue drops the whole message and reports it on its last
// byte. A matching valid ACK gives a timer-stop beat and, if a message is
// queued, streams it from the queue memory (a priming read, then one read a
// cycle while the output is free) plus a timer-start beat. Expiry resends
// the kept packet from the resend memory the same way. The packet check runs
// in its own state after its last byte. A short queued message is filled up
// with zeros in the queue memory. Input is not taken while a burst runs.
// The output register holds a beat while m_axis_tready is low; the block
// stalls its burst and its input then. Reset empties queue and state and
// loads the timeout with 20; memories are not cleared.
// Depends on abs_pkg, abs_ctrl, abs_queue_mem, abs_resend_mem.
module alternating_bit_sender_unit import abs_pkg::*; #(
  parameter int MESSAGE_BYTES = MESSAGE_BYTES_DEFAULT,
  parameter int QUEUE_DEPTH   = QUEUE_DEPTH_DEFAULT
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         timeout_wr_en,
  input  logic [15:0]  timeout_wr_data,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // data_byte[7:0], pkt_seqnum[39:8], pkt_acknum[71:40], pkt_checksum[103:72]
  input  logic [103:0] s_axis_tdata,
  input  logic         s_axis_tlast,
  // command[1:0]
  input  logic [1:0]   s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // out_seqnum[0], out_checksum[32:1], out_byte[40:33], out_timeout[56:41], zero[63:57]
  output logic [63:0]  m_axis_tdata,
  output logic         m_axis_tlast,
  // kind[1:0]
  output logic [1:0]   m_axis_tuser
);

  localparam int IDX_W  = (MESSAGE_BYTES > 1) ? $clog2(MESSAGE_BYTES) : 1;
  localparam int SLOT_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

  item_t             item;
  result_t           result;
  mem_ctl_t          q_ctl;
  mem_ctl_t          r_ctl;
  logic [SLOT_W-1:0] q_wslot, q_rslot;
  logic [IDX_W-1:0]  q_widx, q_ridx, r_widx, r_ridx;
  logic [7:0]        q_wdata, q_rdata, r_wdata, r_rdata;

  assign item.command      = s_axis_tuser;
  assign item.data_byte    = s_axis_tdata[7:0];
  assign item.last_byte    = s_axis_tlast;
  assign item.pkt_seqnum   = s_axis_tdata[39:8];
  assign item.pkt_acknum   = s_axis_tdata[71:40];
  assign item.pkt_checksum = s_axis_tdata[103:72];

  assign m_axis_tdata = {7'd0, result.out_timeout, result.out_byte,
                         result.out_checksum, result.out_seqnum};
  assign m_axis_tlast = result.out_last;
  assign m_axis_tuser = result.kind;

  abs_ctrl #(
    .MESSAGE_BYTES (MESSAGE_BYTES),
    .QUEUE_DEPTH   (QUEUE_DEPTH)
  ) u_ctrl (
    .clk             (clk),
    .rst             (rst),
    .timeout_wr_en   (timeout_wr_en),
    .timeout_wr_data (timeout_wr_data),
    .in_valid        (s_axis_tvalid),
    .in_ready        (s_axis_tready),
    .item            (item),
    .out_valid       (m_axis_tvalid),
    .out_ready       (m_axis_tready),
    .result          (result),
    .q_ctl           (q_ctl),
    .q_wslot         (q_wslot),
    .q_widx          (q_widx),
    .q_wdata         (q_wdata),
    .q_rslot         (q_rslot),
    .q_ridx          (q_ridx),
    .q_rdata         (q_rdata),
    .r_ctl           (r_ctl),
    .r_widx          (r_widx),
    .r_wdata         (r_wdata),
    .r_ridx          (r_ridx),
    .r_rdata         (r_rdata)
  );

  abs_queue_mem #(
    .MESSAGE_BYTES (MESSAGE_BYTES),
    .QUEUE_DEPTH   (QUEUE_DEPTH)
  ) u_queue_mem (
    .clk     (clk),
    .ctl     (q_ctl),
    .wr_slot (q_wslot),
    .wr_idx  (q_widx),
    .wr_data (q_wdata),
    .rd_slot (q_rslot),
    .rd_idx  (q_ridx),
    .rd_data (q_rdata)
  );

  abs_resend_mem #(
    .MESSAGE_BYTES (MESSAGE_BYTES)
  ) u_resend_mem (
    .clk     (clk),
    .ctl     (r_ctl),
    .wr_idx  (r_widx),
    .wr_data (r_wdata),
    .rd_idx  (r_ridx),
    .rd_data (r_rdata)
  );

endmodule

### bench/abs_sender_checker.sv
// Scoreboard for the alternating-bit sender: watches both stream ports and the
// timeout write port, predicts each output beat and compares it field by field.
// Depends on abs_pkg.
`timescale 1ns / 100ps
module abs_sender_checker import abs_pkg::*; #(
  parameter int MESSAGE_BYTES = MESSAGE_BYTES_DEFAULT,
  parameter int QUEUE_DEPTH   = QUEUE_DEPTH_DEFAULT
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         timeout_wr_en,
  input  logic [15:0]  timeout_wr_data,
  input  logic         s_axis_tvalid,
  input  logic         s_axis_tready,
  input  logic [103:0] s_axis_tdata,
  input  logic         s_axis_tlast,
  input  logic [1:0]   s_axis_tuser,
  input  logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  input  logic [63:0]  m_axis_tdata,
  input  logic         m_axis_tlast,
  input  logic [1:0]   m_axis_tuser,
  output int           errors,
  output int           pending
);

  logic [15:0] timeout_val;
  logic        seq_bit;
  logic        awaiting_ack;
  logic        queued_mode;
  logic        tx_zero_seen;
  logic [7:0]  resend_buf [MESSAGE_BYTES];
  logic [31:0] resend_sum;
  logic [7:0]  queue_mem [QUEUE_DEPTH * MESSAGE_BYTES];
  int unsigned q_head;
  int unsigned q_count;
  int unsigned tx_idx;
  int unsigned rx_idx;
  logic [31:0] tx_acc;
  logic [31:0] rx_acc;
  result_t     beats_due [$];

  function automatic logic [31:0] sext8(input logic [7:0] b);
    return {{24{b[7]}}, b};
  endfunction

  function automatic logic [31:0] close_sum(input logic [31:0] hdr, input logic [31:0] acc,
                                            input int unsigned n);
    return ~((hdr << MESSAGE_BYTES) + (acc << (MESSAGE_BYTES - n)));
  endfunction

  function void push_beat(input kind_t k, input logic s, input logic [31:0] c,
                          input logic [7:0] b, input logic l, input logic [15:0] t);
    result_t r;
    r.kind = k;
    r.out_seqnum = s;
    r.out_checksum = c;
    r.out_byte = b;
    r.out_last = l;
    r.out_timeout = t;
    beats_due.push_back(r);
  endfunction

  function void start_timer();
    awaiting_ack = 1'b1;
    push_beat(KIND_TSTART, 1'b0, 32'd0, 8'd0, 1'b0, timeout_val);
  endfunction

  function void resend_packet();
    logic fin;
    for (int i = 0; i < MESSAGE_BYTES; i++) begin
      fin = (i == MESSAGE_BYTES - 1);
      push_beat(KIND_BYTE, seq_bit, fin ? resend_sum : 32'd0, resend_buf[i], fin, 16'd0);
    end
    start_timer();
  endfunction

  function void send_queue_head();
    int unsigned base;
    logic        zero;
    logic [7:0]  b;
    logic [31:0] acc;
    base = (q_head % QUEUE_DEPTH) * MESSAGE_BYTES;
    zero = 1'b0;
    acc = 32'd0;
    for (int i = 0; i < MESSAGE_BYTES; i++) begin
      b = zero ? 8'd0 : queue_mem[base + i];
      if (b == 8'd0) zero = 1'b1;
      resend_buf[i] = b;
      acc = (acc << 1) + sext8(b);
    end
    q_head = (q_head + 1) % QUEUE_DEPTH;
    q_count--;
    resend_sum = close_sum({31'd0, seq_bit}, acc, MESSAGE_BYTES);
    resend_packet();
  endfunction

  function void predict_message_byte(input logic [7:0] d, input logic fin);
    int unsigned base;
    int unsigned n;
    logic [7:0]  b;
    logic        lst;
    if (tx_idx == 0) begin
      queued_mode = awaiting_ack;
      tx_zero_seen = awaiting_ack && (q_count >= QUEUE_DEPTH);
      tx_acc = 32'd0;
    end
    if (queued_mode) begin
      base = ((q_head + q_count) % QUEUE_DEPTH) * MESSAGE_BYTES;
      if (!tx_zero_seen) queue_mem[base + tx_idx] = d;
      tx_idx++;
      if (!fin) return;
      if (tx_zero_seen) begin
        push_beat(KIND_DROP, 1'b0, 32'd0, 8'd0, 1'b0, 16'd0);
      end else begin
        for (; tx_idx < MESSAGE_BYTES; tx_idx++) queue_mem[base + tx_idx] = 8'd0;
        q_count++;
        if (!awaiting_ack) send_queue_head();
      end
    end else begin
      b = tx_zero_seen ? 8'd0 : d;
      if (b == 8'd0) tx_zero_seen = 1'b1;
      resend_buf[tx_idx] = b;
      tx_acc = (tx_acc << 1) + sext8(b);
      tx_idx++;
      if (!fin) begin
        push_beat(KIND_BYTE, seq_bit, 32'd0, b, 1'b0, 16'd0);
        return;
      end
      n = tx_idx;
      for (; tx_idx < MESSAGE_BYTES; tx_idx++) resend_buf[tx_idx] = 8'd0;
      resend_sum = close_sum({31'd0, seq_bit}, tx_acc, n);
      if (n == MESSAGE_BYTES) begin
        push_beat(KIND_BYTE, seq_bit, resend_sum, b, 1'b1, 16'd0);
      end else begin
        push_beat(KIND_BYTE, seq_bit, 32'd0, b, 1'b0, 16'd0);
        for (int i = n; i < MESSAGE_BYTES; i++) begin
          lst = (i == MESSAGE_BYTES - 1);
          push_beat(KIND_BYTE, seq_bit, lst ? resend_sum : 32'd0, 8'd0, lst, 16'd0);
        end
      end
      start_timer();
    end
    tx_idx = 0;
    tx_zero_seen = 1'b0;
    queued_mode = 1'b0;
    tx_acc = 32'd0;
  endfunction

  function void predict_packet_byte(input logic [7:0] d, input logic fin,
                                    input logic [31:0] seqn, input logic [31:0] ackn,
                                    input logic [31:0] chk);
    logic [31:0] sum;
    rx_acc = (rx_acc << 1) + sext8(d);
    rx_idx++;
    if (!fin) return;
    sum = close_sum(seqn + ackn, rx_acc, rx_idx);
    rx_acc = 32'd0;
    rx_idx = 0;
    if (!awaiting_ack || sum != chk || ackn != {31'd0, seq_bit}) return;
    push_beat(KIND_TSTOP, 1'b0, 32'd0, 8'd0, 1'b0, 16'd0);
    seq_bit = ~seq_bit;
    awaiting_ack = 1'b0;
    if (q_count > 0) send_queue_head();
  endfunction

  function void check_field(input string name, input logic [31:0] want,
                            input logic [31:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t ns: %s mismatch, expected %h, got %h", $time, name, want, got);
    end
  endfunction

  function void compare_beat();
    result_t e;
    if (beats_due.size() == 0) begin
      errors++;
      $display("%0t ns: unexpected beat, kind %0d data %h last %b", $time,
               m_axis_tuser, m_axis_tdata, m_axis_tlast);
      return;
    end
    e = beats_due.pop_front();
    check_field("kind", 32'(e.kind), 32'(m_axis_tuser));
    check_field("out_seqnum", 32'(e.out_seqnum), 32'(m_axis_tdata[0]));
    check_field("out_checksum", e.out_checksum, m_axis_tdata[32:1]);
    check_field("out_byte", 32'(e.out_byte), 32'(m_axis_tdata[40:33]));
    check_field("out_last", 32'(e.out_last), 32'(m_axis_tlast));
    check_field("out_timeout", 32'(e.out_timeout), 32'(m_axis_tdata[56:41]));
    check_field("tdata pad", 32'd0, 32'(m_axis_tdata[63:57]));
  endfunction

  function void predict_beat();
    logic [7:0] d;
    d = s_axis_tdata[7:0];
    case (s_axis_tuser)
      CMD_MESSAGE: predict_message_byte(d, s_axis_tlast || (tx_idx + 1 >= MESSAGE_BYTES));
      CMD_PACKET:  predict_packet_byte(d, s_axis_tlast || (rx_idx + 1 >= MESSAGE_BYTES),
                                       s_axis_tdata[39:8], s_axis_tdata[71:40],
                                       s_axis_tdata[103:72]);
      CMD_EXPIRY:  if (awaiting_ack) resend_packet();
      default: ;
    endcase
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      timeout_val = TIMEOUT_RESET;
      seq_bit = 1'b0;
      awaiting_ack = 1'b0;
      queued_mode = 1'b0;
      tx_zero_seen = 1'b0;
      q_head = 0;
      q_count = 0;
      tx_idx = 0;
      rx_idx = 0;
      tx_acc = 32'd0;
      rx_acc = 32'd0;
      errors = 0;
      beats_due.delete();
    end else begin
      if (m_axis_tvalid && m_axis_tready) compare_beat();
      if (timeout_wr_en) timeout_val = timeout_wr_data;
      if (s_axis_tvalid && s_axis_tready) predict_beat();
    end
    pending = beats_due.size();
  end

endmodule

### bench/tb_alternating_bit_sender_unit.sv
// Top of the alternating-bit sender bench: clock, reset, stimulus on the input
// stream and the timeout port, random output back-pressure, and the verdict.
// Depends on abs_pkg, alternating_bit_sender_unit and abs_sender_checker.
`timescale 1ns / 100ps
module tb_alternating_bit_sender_unit import abs_pkg::*;;

  localparam int MB = MESSAGE_BYTES_DEFAULT;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         timeout_wr_en = 1'b0;
  logic [15:0]  timeout_wr_data = 16'd0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [103:0] s_axis_tdata = '0;
  logic         s_axis_tlast = 1'b0;
  logic [1:0]   s_axis_tuser = CMD_MESSAGE;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [63:0]  m_axis_tdata;
  logic         m_axis_tlast;
  logic [1:0]   m_axis_tuser;

  int   errors;
  int   pending;
  logic in_taken = 1'b0;
  int   items_sent = 0;
  int   send_idle_pct = 0;
  int   recv_idle_pct = 0;
  bit   hold_req = 1'b0;
  bit   hold_done = 1'b0;
  int   hold_left = 0;
  int   recv_gap = 0;
  logic [7:0] pkt_data [MB];

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  alternating_bit_sender_unit u_top (
    .clk             (clk),
    .rst             (rst),
    .timeout_wr_en   (timeout_wr_en),
    .timeout_wr_data (timeout_wr_data),
    .s_axis_tvalid   (s_axis_tvalid),
    .s_axis_tready   (s_axis_tready),
    .s_axis_tdata    (s_axis_tdata),
    .s_axis_tlast    (s_axis_tlast),
    .s_axis_tuser    (s_axis_tuser),
    .m_axis_tvalid   (m_axis_tvalid),
    .m_axis_tready   (m_axis_tready),
    .m_axis_tdata    (m_axis_tdata),
    .m_axis_tlast    (m_axis_tlast),
    .m_axis_tuser    (m_axis_tuser)
  );

  abs_sender_checker u_checker (
    .clk             (clk),
    .rst             (rst),
    .timeout_wr_en   (timeout_wr_en),
    .timeout_wr_data (timeout_wr_data),
    .s_axis_tvalid   (s_axis_tvalid),
    .s_axis_tready   (s_axis_tready),
    .s_axis_tdata    (s_axis_tdata),
    .s_axis_tlast    (s_axis_tlast),
    .s_axis_tuser    (s_axis_tuser),
    .m_axis_tvalid   (m_axis_tvalid),
    .m_axis_tready   (m_axis_tready),
    .m_axis_tdata    (m_axis_tdata),
    .m_axis_tlast    (m_axis_tlast),
    .m_axis_tuser    (m_axis_tuser),
    .errors          (errors),
    .pending         (pending)
  );

  always @(posedge clk) in_taken <= s_axis_tvalid && s_axis_tready;

  // output back-pressure: one long hold on request, else random bursts
  always @(negedge clk) begin
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else if (hold_req && !hold_done) begin
      hold_done = 1'b1;
      hold_left = 299;
      m_axis_tready <= 1'b0;
    end else if (recv_gap > 0) begin
      recv_gap--;
      m_axis_tready <= 1'b0;
    end else if (recv_idle_pct != 0 && $urandom_range(99) < recv_idle_pct) begin
      recv_gap = $urandom_range(0, 9);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  task automatic send_item(input logic [1:0] cmd, input logic [7:0] data, input logic fin,
                           input logic [31:0] seqn, input logic [31:0] ackn,
                           input logic [31:0] chk);
    if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {chk, ackn, seqn, data};
    s_axis_tlast <= fin;
    s_axis_tuser <= cmd;
    do @(negedge clk); while (!in_taken);
    if (cmd != CMD_SPARE) items_sent++;
  endtask

  function automatic logic [7:0] rand_data();
    return ($urandom_range(4) == 0) ? 8'h00 : 8'($urandom);
  endfunction

  function automatic int rand_len();
    int r;
    r = $urandom_range(99);
    if (r < 70) return $urandom_range(1, 4);
    if (r < 90) return $urandom_range(5, MB - 1);
    return MB;
  endfunction

  // network packet; a bad one carries a checksum with one bit flipped
  task automatic send_packet(input int len, input logic [31:0] seqn,
                             input logic [31:0] ackn, input bit bad);
    logic [31:0] acc;
    logic [31:0] chk;
    logic        fin;
    acc = 32'd0;
    for (int i = 0; i < len; i++) begin
      pkt_data[i] = 8'($urandom);
      acc = (acc << 1) + {{24{pkt_data[i][7]}}, pkt_data[i]};
    end
    chk = ~(((seqn + ackn) << MB) + (acc << (MB - len)));
    if (bad) chk[$urandom_range(31)] ^= 1'b1;
    for (int i = 0; i < len; i++) begin
      fin = (i == len - 1) && (len < MB || $urandom_range(1));
      send_item(CMD_PACKET, pkt_data[i], fin, seqn, ackn, chk);
    end
  endtask

  task automatic send_message(input int len, input bit with_ack);
    logic fin;
    for (int i = 0; i < len; i++) begin
      if (with_ack && i == len / 2)
        send_packet($urandom_range(1, 3), $urandom, 32'($urandom_range(1)), 1'b0);
      fin = (i == len - 1) && (len < MB || $urandom_range(1));
      send_item(CMD_MESSAGE, rand_data(), fin, $urandom, $urandom, $urandom);
    end
  endtask

  task automatic random_action();
    int r;
    r = $urandom_range(99);
    if (r < 40) begin
      send_message(rand_len(), 1'b0);
    end else if (r < 65) begin
      send_packet(($urandom_range(9) == 0) ? MB : $urandom_range(1, 3),
                  $urandom_range(1) ? $urandom : 32'($urandom_range(1)),
                  32'($urandom_range(1)), 1'b0);
    end else if (r < 72) begin
      send_packet($urandom_range(1, 3), $urandom,
                  $urandom_range(1) ? $urandom : 32'($urandom_range(1)),
                  1'($urandom_range(1)));
    end else if (r < 82) begin
      send_item(CMD_EXPIRY, 8'($urandom), 1'($urandom_range(1)), $urandom, $urandom,
                $urandom);
    end else if (r < 86) begin
      send_item(CMD_SPARE, 8'($urandom), 1'($urandom_range(1)), $urandom, $urandom,
                $urandom);
    end else if (r < 90) begin
      // enough messages to overflow the queue while an ACK is pending
      for (int k = 0; k < QUEUE_DEPTH_DEFAULT + 2; k++)
        send_message($urandom_range(1, 2), 1'b0);
    end else begin
      send_message($urandom_range(2, 6), 1'b1);
    end
  endtask

  // wait for every expected beat, then let a zero-fill of a queued message finish
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    repeat (40) @(negedge clk);
  endtask

  task automatic write_timeout(input logic [15:0] v);
    timeout_wr_en <= 1'b1;
    timeout_wr_data <= v;
    @(negedge clk);
    timeout_wr_en <= 1'b0;
  endtask

  task automatic run_phase(input int target);
    while (items_sent < target) random_action();
  endtask

  initial begin
    #4_000_000;
    $display("FAIL alternating_bit_sender_unit");
    $finish;
  end

  initial begin
    repeat (7) @(negedge clk);
    rst <= 1'b0;
    send_idle_pct = 20;
    recv_idle_pct = 20;

    send_item(CMD_EXPIRY, 8'h00, 1'b0, 32'd0, 32'd0, 32'd0);
    send_packet(1, 32'd0, 32'd0, 1'b0);
    send_item(CMD_MESSAGE, 8'hFF, 1'b1, 32'd0, 32'd0, 32'd0);
    send_item(CMD_MESSAGE, 8'h80, 1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_item(CMD_MESSAGE, 8'h00, 1'b1, 32'd0, 32'd0, 32'd0);
    send_item(CMD_EXPIRY, 8'hFF, 1'b1, 32'd0, 32'd0, 32'd0);
    send_packet(1, 32'd0, 32'd0, 1'b1);
    send_packet(1, 32'd0, 32'd1, 1'b0);
    send_packet(1, 32'h7FFF_FFFF, 32'd0, 1'b0);
    // message begins while waiting, the ACK lands before its last byte
    send_item(CMD_MESSAGE, 8'h01, 1'b0, 32'd0, 32'd0, 32'd0);
    send_packet(1, 32'h8000_0000, 32'd1, 1'b0);
    send_item(CMD_MESSAGE, 8'h7F, 1'b1, 32'd0, 32'd0, 32'd0);
    send_packet(1, $urandom, 32'd0, 1'b0);
    send_item(CMD_MESSAGE, 8'h05, 1'b0, 32'd0, 32'd0, 32'd0);
    send_item(CMD_MESSAGE, 8'h00, 1'b0, 32'd0, 32'd0, 32'd0);
    send_item(CMD_MESSAGE, 8'h07, 1'b1, 32'd0, 32'd0, 32'd0);
    send_item(CMD_SPARE, 8'hFF, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_packet(1, $urandom, 32'd1, 1'b0);
    drain();

    write_timeout(16'd1);
    send_idle_pct = 30;
    recv_idle_pct = 30;
    run_phase(100);
    drain();

    write_timeout(16'($urandom_range(2, 65534)));
    send_idle_pct = 10;
    recv_idle_pct = 40;
    hold_req = 1'b1;
    run_phase(180);
    drain();

    write_timeout(16'hFFFF);
    send_idle_pct = 25;
    recv_idle_pct = 5;
    run_phase(260);
    drain();

    write_timeout(16'($urandom_range(1, 65535)));
    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_phase(335);
    drain();

    if (errors == 0)
      $display("PASS alternating_bit_sender_unit");
    else
      $display("FAIL alternating_bit_sender_unit");
    $finish;
  end

endmodule
